### src/stcr_pkg.sv
// shared types and constants for the scope trigger column renderer
package stcr_pkg;

  localparam int unsigned LevelW = 4;
  localparam int unsigned IndexW = 8;
  localparam int unsigned StartW = 7;
  localparam int unsigned MaskW  = 16;

  localparam logic [LevelW-1:0] TrigLowLevel  = 4'd7;
  localparam logic [LevelW-1:0] TrigHighLevel = 4'd8;
  localparam logic [IndexW-1:0] TrigFirstIdx  = 8'd9;
  localparam logic [IndexW-1:0] TrigEndIdx    = 8'd100;
  localparam logic [IndexW-1:0] TrigOffset    = 8'd8;
  localparam logic [MaskW-1:0]  FullMask      = 16'hffff;
  localparam logic [LevelW-1:0] TopRow        = 4'd15;

  localparam logic EdgeRising  = 1'b0;
  localparam logic EdgeFalling = 1'b1;

  typedef struct packed {
    logic [MaskW-1:0]  column_mask;
    logic [IndexW-1:0] sample_index;
    logic              trigger_found;
    logic [StartW-1:0] trigger_start;
    logic              capture_last;
  } result_t;

endpackage

### src/scope_trigger_column_render.sv
// scope trigger column renderer: one 16-row bar column and trigger search per sample
//
// in channel: raw_sample and capture_start qualified by in_valid, accepted when
// in_valid is high and in_stall is low. out channel: column_mask, sample_index,
// trigger_found, trigger_start and capture_last qualified by out_valid, taken
// when out_stall is low. cfg_we writes cfg_wdata into the trigger edge register
// (0 rising, 1 falling); write it only while no word is in flight.
// Each sample gives one registered word. One sample per cycle is sustained while
// out_stall is low: the column mask and trigger compare are a single level of
// logic between the input handshake and the output register.
// A one-word skid buffer behind the output register lets one more sample in
// while the receiver stalls; in_stall rises only once that buffer is full.
// A capture holds CAPTURE_LEN-1 samples; capture_start or the end of a capture
// restarts the index and the trigger search.
// Reset (rst, synchronous) empties the output and skid stages, clears the edge
// register and makes the next sample index 0 of a new capture.
module scope_trigger_column_render #(
  parameter int unsigned CAPTURE_LEN = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic                            cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [5:0]                      raw_sample,
  input  logic                            capture_start,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [stcr_pkg::MaskW-1:0]      column_mask,
  output logic [stcr_pkg::IndexW-1:0]     sample_index,
  output logic                            trigger_found,
  output logic [stcr_pkg::StartW-1:0]     trigger_start,
  output logic                            capture_last
);

  localparam logic [stcr_pkg::IndexW-1:0] LastIndex = stcr_pkg::IndexW'(CAPTURE_LEN - 2);
  localparam logic [stcr_pkg::IndexW-1:0] WrapIndex = stcr_pkg::IndexW'(CAPTURE_LEN - 1);

  logic                          trigger_edge;
  logic [stcr_pkg::LevelW-1:0]   prev_level;
  logic [stcr_pkg::IndexW-1:0]   position;
  logic                          found;
  logic [stcr_pkg::StartW-1:0]   start_col;

  stcr_pkg::result_t             out_word;
  stcr_pkg::result_t             skid_word;
  logic                          skid_valid;

  logic                          in_fire;
  logic                          out_free;
  logic                          restart;
  logic [stcr_pkg::LevelW-1:0]   level;
  logic [stcr_pkg::IndexW-1:0]   idx;
  logic                          found_base;
  logic [stcr_pkg::StartW-1:0]   start_base;
  logic [stcr_pkg::LevelW-1:0]   lo;
  logic [stcr_pkg::LevelW-1:0]   hi;
  logic                          edge_ok;
  logic                          hit;
  logic                          is_last;
  logic                          found_next;
  logic [stcr_pkg::StartW-1:0]   start_col_next;
  logic [stcr_pkg::IndexW-1:0]   position_next;
  logic [stcr_pkg::IndexW-1:0]   hit_col;
  stcr_pkg::result_t             new_word;

  assign in_stall = skid_valid;
  assign in_fire  = in_valid && !skid_valid;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    level      = raw_sample[5:2];
    restart    = capture_start || (position > LastIndex);
    idx        = restart ? '0 : position;
    found_base = restart ? 1'b0 : found;
    start_base = restart ? '0 : start_col;

    // first sample of a capture draws a single dot
    if (idx == '0) begin
      lo = level;
      hi = level;
    end else if (level < prev_level) begin
      lo = level;
      hi = prev_level;
    end else begin
      lo = prev_level;
      hi = level;
    end

    edge_ok = ((trigger_edge == stcr_pkg::EdgeRising) && (prev_level < level)) ||
              ((trigger_edge == stcr_pkg::EdgeFalling) && (prev_level > level));
    hit = (idx != '0) && !found_base &&
          (idx >= stcr_pkg::TrigFirstIdx) && (idx < stcr_pkg::TrigEndIdx) &&
          (lo <= stcr_pkg::TrigLowLevel) && (hi >= stcr_pkg::TrigHighLevel) && edge_ok;

    hit_col        = idx - stcr_pkg::TrigOffset;
    found_next     = found_base || hit;
    start_col_next = hit ? hit_col[stcr_pkg::StartW-1:0] : start_base;
    is_last        = (idx == LastIndex);
    // past the last sample the counter parks beyond it, forcing a restart
    position_next  = is_last ? WrapIndex : idx + 1'b1;

    new_word.column_mask   = (stcr_pkg::FullMask << (stcr_pkg::TopRow - hi)) &
                             (stcr_pkg::FullMask >> lo);
    new_word.sample_index  = idx;
    new_word.trigger_found = found_next;
    new_word.trigger_start = start_col_next;
    new_word.capture_last  = is_last;
  end

  // capture state
  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_edge <= stcr_pkg::EdgeRising;
      prev_level   <= '0;
      position     <= '0;
      found        <= 1'b0;
      start_col    <= '0;
    end else begin
      if (cfg_we) begin
        trigger_edge <= cfg_wdata;
      end
      if (in_fire) begin
        prev_level <= level;
        position   <= position_next;
        found      <= found_next;
        start_col  <= start_col_next;
      end
    end
  end

  // output register with one-word skid buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_word <= skid_word;
      end else if (in_fire) begin
        out_word <= new_word;
      end
    end else if (in_fire) begin
      skid_word <= new_word;
    end
  end

  assign column_mask   = out_word.column_mask;
  assign sample_index  = out_word.sample_index;
  assign trigger_found = out_word.trigger_found;
  assign trigger_start = out_word.trigger_start;
  assign capture_last  = out_word.capture_last;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held without an output word");

  a_start_zero_until_found: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !trigger_found) |-> (trigger_start == '0))
    else $error("trigger start set without a trigger");

  a_start_in_window: assert property (@(posedge clk) disable iff (rst)
    (out_valid && trigger_found) |->
      ((trigger_start >= 7'd1) && (trigger_start <= 7'd91)))
    else $error("trigger start outside the search window");

  a_last_at_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && capture_last) |-> (sample_index == LastIndex))
    else $error("last flag away from the final index");

  a_index_follows: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !capture_start && (position != '0) && (position <= LastIndex)) |=>
      (position == $past(position) + 1'b1 || position == WrapIndex))
    else $error("sample index did not advance");

endmodule

### tb/tb_scope_trigger_column_render.sv
// testbench for the scope trigger column renderer: random waveforms, both edges, random stalls
module tb_scope_trigger_column_render;

  localparam int unsigned CaptureLen = 256;
  localparam logic [stcr_pkg::IndexW-1:0] LastIdx = stcr_pkg::IndexW'(CaptureLen - 2);
  localparam int unsigned RandomSamples = 900;
  localparam int unsigned MaxPrinted = 40;

  // waveform shapes for random captures
  localparam int ModeNoise  = 0;
  localparam int ModeSquare = 1;
  localparam int ModeFlat   = 2;
  localparam int ModeStep   = 3;

  class column_checker;
    logic                        trig_edge;
    logic [stcr_pkg::LevelW-1:0] prev_level;
    logic [stcr_pkg::IndexW-1:0] next_index;
    logic                        found;
    logic [stcr_pkg::StartW-1:0] start_col;
    stcr_pkg::result_t           expected_columns[$];
    int                          mismatches;
    int                          words_checked;
    int                          triggers;

    function new();
      clear();
    endfunction

    function void clear();
      trig_edge = stcr_pkg::EdgeRising;
      prev_level = '0;
      next_index = '0;
      found = 1'b0;
      start_col = '0;
    endfunction

    // rows 15-hi through 15-lo lit
    function logic [stcr_pkg::MaskW-1:0] bar(logic [stcr_pkg::LevelW-1:0] lo,
                                             logic [stcr_pkg::LevelW-1:0] hi);
      logic [stcr_pkg::MaskW-1:0] m;
      int k;
      m = '0;
      for (k = 0; k < stcr_pkg::MaskW; k++)
        if (k >= int'(stcr_pkg::TopRow) - int'(hi) &&
            k <= int'(stcr_pkg::TopRow) - int'(lo)) m[k] = 1'b1;
      return m;
    endfunction

    function void note_sample(logic [5:0] raw, logic start);
      logic [stcr_pkg::LevelW-1:0] level;
      logic [stcr_pkg::LevelW-1:0] lo;
      logic [stcr_pkg::LevelW-1:0] hi;
      logic [stcr_pkg::IndexW-1:0] idx;
      stcr_pkg::result_t r;
      level = raw[5:2];
      if (start || next_index > LastIdx) begin
        next_index = '0;
        found = 1'b0;
        start_col = '0;
      end
      idx = next_index;
      if (idx == '0) begin
        lo = level;
        hi = level;
      end else begin
        lo = (level < prev_level) ? level : prev_level;
        hi = (level < prev_level) ? prev_level : level;
        if (!found && idx >= stcr_pkg::TrigFirstIdx && idx < stcr_pkg::TrigEndIdx &&
            lo <= stcr_pkg::TrigLowLevel && hi >= stcr_pkg::TrigHighLevel) begin
          if ((trig_edge == stcr_pkg::EdgeRising && prev_level < level) ||
              (trig_edge == stcr_pkg::EdgeFalling && prev_level > level)) begin
            found = 1'b1;
            start_col = stcr_pkg::StartW'(idx - stcr_pkg::TrigOffset);
            triggers++;
          end
        end
      end
      r.column_mask = bar(lo, hi);
      r.sample_index = idx;
      r.trigger_found = found;
      r.trigger_start = start_col;
      r.capture_last = (idx == LastIdx);
      prev_level = level;
      // past the last sample the index parks above the end, forcing a restart
      next_index = (idx == LastIdx) ? stcr_pkg::IndexW'(LastIdx + 1)
                                    : stcr_pkg::IndexW'(idx + 1);
      expected_columns.push_back(r);
    endfunction

    task report(string msg);
      if (mismatches < MaxPrinted) $display("%0t mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_word(stcr_pkg::result_t got);
      stcr_pkg::result_t want;
      if (expected_columns.size() == 0) begin
        report("word arrived with nothing expected");
        return;
      end
      want = expected_columns.pop_front();
      words_checked++;
      if (got.column_mask !== want.column_mask)
        report($sformatf("column_mask %h, expected %h (index %0d)",
                         got.column_mask, want.column_mask, want.sample_index));
      if (got.sample_index !== want.sample_index)
        report($sformatf("sample_index %0d, expected %0d", got.sample_index, want.sample_index));
      if (got.trigger_found !== want.trigger_found)
        report($sformatf("trigger_found %b, expected %b (index %0d)",
                         got.trigger_found, want.trigger_found, want.sample_index));
      if (got.trigger_start !== want.trigger_start)
        report($sformatf("trigger_start %0d, expected %0d (index %0d)",
                         got.trigger_start, want.trigger_start, want.sample_index));
      if (got.capture_last !== want.capture_last)
        report($sformatf("capture_last %b, expected %b (index %0d)",
                         got.capture_last, want.capture_last, want.sample_index));
    endtask
  endclass

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_we = 1'b0;
  logic                          cfg_wdata = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [5:0]                    raw_sample = '0;
  logic                          capture_start = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [stcr_pkg::MaskW-1:0]    column_mask;
  logic [stcr_pkg::IndexW-1:0]   sample_index;
  logic                          trigger_found;
  logic [stcr_pkg::StartW-1:0]   trigger_start;
  logic                          capture_last;

  column_checker sb = new();
  int captures = 0;

  scope_trigger_column_render #(.CAPTURE_LEN(CaptureLen)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .raw_sample(raw_sample),
    .capture_start(capture_start),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .column_mask(column_mask),
    .sample_index(sample_index),
    .trigger_found(trigger_found),
    .trigger_start(trigger_start),
    .capture_last(capture_last)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_word(stcr_pkg::result_t'({column_mask, sample_index, trigger_found,
                                         trigger_start, capture_last}));
  end

  // receiver: free stretches, short stalls and the odd long one
  initial begin
    int free_run;
    int hold;
    forever begin
      free_run = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 6);
      out_stall <= 1'b0;
      repeat (free_run) @(posedge clk);
      hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      out_stall <= 1'b1;
      repeat (hold) @(posedge clk);
    end
  end

  initial begin
    #4000000;
    $display("timeout with %0d words still expected", sb.expected_columns.size());
    $display("tb_scope_trigger_column_render NOT OK");
    $finish;
  end

  function int pick_gap(bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task send_sample(input logic [5:0] raw, input logic start, input int gap);
    in_valid <= 1'b1;
    raw_sample <= raw;
    capture_start <= start;
    do @(posedge clk); while (in_stall);
    sb.note_sample(raw, start);
    if (start) captures++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // wait until every word is back, then let the pipeline empty
  task settle();
    in_valid <= 1'b0;
    while (sb.expected_columns.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_edge(input logic value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.trig_edge = value;
  endtask

  task send_directed(input logic [5:0] raws[], input int first_start);
    int i;
    for (i = 0; i < raws.size(); i++)
      send_sample(raws[i], (i == 0 || i == first_start), pick_gap(1'b0));
  endtask

  function logic [5:0] wave_sample(int mode, int i, int period, int step_at, bit high_first);
    case (mode)
      ModeNoise:  return 6'($urandom_range(0, 63));
      ModeSquare: return ((i / period) % 2) ? 6'($urandom_range(32, 63))
                                            : 6'($urandom_range(0, 31));
      ModeFlat:   return 6'($urandom_range(26, 37));
      default: begin
        if ((i < step_at) == high_first) return 6'($urandom_range(32, 63));
        return 6'($urandom_range(0, 31));
      end
    endcase
  endfunction

  task send_capture(output int sent);
    int mode;
    int len;
    int r;
    int period;
    int step_at;
    int i;
    bit high_first;
    bit burst;
    bit lead_start;
    logic start;
    mode = $urandom_range(ModeNoise, ModeStep);
    r = $urandom_range(0, 9);
    len = (r < 7) ? $urandom_range(12, 110) :
          (r < 9) ? $urandom_range(111, 254) : $urandom_range(255, 300);
    period = $urandom_range(1, 12);
    step_at = $urandom_range(5, 105);
    high_first = $urandom_range(0, 1);
    burst = ($urandom_range(0, 3) == 0);
    lead_start = ($urandom_range(0, 7) != 0);
    for (i = 0; i < len; i++) begin
      // an occasional start flag in mid capture breaks the sequence
      start = (i == 0) ? lead_start : ($urandom_range(0, 59) == 0);
      send_sample(wave_sample(mode, i, period, step_at, high_first), start, pick_gap(burst));
    end
    sent = len;
  endtask

  initial begin
    int total;
    int sent;
    int ph;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    write_edge(stcr_pkg::EdgeRising);

    // rising edge: extremes, equal levels, a crossing too early, the first valid
    // crossing at index 9, no second trigger, then a falling crossing ignored
    send_directed('{6'd63, 6'd0, 6'd3, 6'd60, 6'd28, 6'd32, 6'd28, 6'd28, 6'd28,
                    6'd32, 6'd0, 6'd63, 6'd32, 6'd28}, 12);
    settle();
    write_edge(stcr_pkg::EdgeFalling);
    // falling edge: equal levels at the top, then 10 down to 7 at index 10
    send_directed('{6'd0, 6'd63, 6'd63, 6'd40, 6'd40, 6'd40, 6'd40, 6'd40, 6'd40,
                    6'd40, 6'd28, 6'd40, 6'd0}, -1);
    settle();

    total = 0;
    for (ph = 0; ph < 4; ph++) begin
      write_edge((ph % 2 == 0) ? stcr_pkg::EdgeRising : stcr_pkg::EdgeFalling);
      while (total < (ph + 1) * RandomSamples / 4) begin
        send_capture(sent);
        total += sent;
      end
      settle();
    end

    repeat (8) @(posedge clk);
    $display("%0d words checked across %0d started captures, %0d triggers on both edges",
             sb.words_checked, captures, sb.triggers);
    if (sb.mismatches == 0 && sb.expected_columns.size() == 0) begin
      $display("tb_scope_trigger_column_render OK");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("tb_scope_trigger_column_render NOT OK");
    end
    $finish;
  end

endmodule
